// ===== hdl/vnf_pkg.sv =====
// ============================================================================
// vnf_pkg - shared types and constants for the fractal value noise block
// item record between front and back, register indexes, weight table builder
// ============================================================================
package vnf_pkg;

    // register indexes of the configuration port
    typedef enum logic
    {
        REG_PERSISTENCE  = 1'b0,
        REG_OCTAVE_COUNT = 1'b1
    } cfg_reg_t;

    localparam logic [15:0] PERSISTENCE_RESET = 16'd32768;
    localparam logic [4:0]  OCTAVE_RESET      = 5'd4;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // one point, with its octave count already clamped
    typedef struct packed
    {
        logic [31:0] x;
        logic [31:0] y;
        logic [4:0]  octaves;
    } item_t;

    // quotient of two non-negative values, restoring long division
    function automatic longint udiv(input longint num, input longint den);
        logic [63:0] n_bits;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] d;
        n_bits = num;
        d      = den;
        q      = '0;
        r      = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n_bits[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return longint'(q);
    endfunction

    // sin^2 weight in q1.16, taylor series in q2.30, evaluated at elaboration
    function automatic logic [16:0] cos_weight(input int k, input int bits);
        longint a;
        longint s;
        longint term;
        longint unsigned w;
        a = (HALF_PI_Q30 * longint'(k)) >>> bits;
        s = a;
        term = a;
        for (int n = 1; n <= 7; n++)
        begin
            term = (((term * a) >>> 30) * a) >>> 30;
            term = udiv(term, longint'((2 * n) * (2 * n + 1)));
            if ((n & 1) != 0)
                s = s - term;
            else
                s = s + term;
        end
        if (s < 0)
            s = 0;
        if (s > (64'sd1 <<< 30))
            s = 64'sd1 <<< 30;
        w = (longint'(unsigned'(s)) * longint'(unsigned'(s)) + (64'd1 << 43)) >> 44;
        if (w > 64'd65536)
            w = 64'd65536;
        return w[16:0];
    endfunction

endpackage

// ===== hdl/value_noise_2d_fractal.sv =====
// ============================================================================
// value_noise_2d_fractal - fractal 2d value noise, cosine interpolated
// one q16.16 point in, one saturated q7.24 noise sum out
// ============================================================================
//
//  channel   signals                                   accepted when
//  --------  ----------------------------------------  ----------------------
//  input     push, full, x_coord, y_coord              push && !full
//  result    empty, pop, noise_value                   pop && !empty
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
//  each octave runs a split, a hash phase (16 lattice points through the
//  shared four-stage hash pipeline), then blend and sum; an item runs one
//  such pass per octave in the sequencer
//  a two-entry queue takes items while the sequencer works; a held result
//  stalls the sequencer only when the next result is ready
//  reset is asynchronous, active low, and loads the register defaults
//
module value_noise_2d_fractal #(
    parameter int MAX_OCTAVES    = 16,
    parameter int COS_TABLE_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] x_coord,
    input  logic [31:0] y_coord,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] noise_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [15:0]    persistence_reg;
    logic [4:0]     octave_reg;

    // front to back item path
    logic           item_valid;
    logic           item_ready;
    vnf_pkg::item_t item;

    // result register between sequencer and output
    logic           res_valid;
    logic           res_ready;
    logic [31:0]    res_data;
    logic           out_valid_reg;
    logic [31:0]    out_data_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            persistence_reg <= vnf_pkg::PERSISTENCE_RESET;
            octave_reg      <= vnf_pkg::OCTAVE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (vnf_pkg::cfg_reg_t'(cfg_index))
                vnf_pkg::REG_PERSISTENCE:  persistence_reg <= cfg_data;
                vnf_pkg::REG_OCTAVE_COUNT: octave_reg      <= cfg_data[4:0];
                default:                   persistence_reg <= persistence_reg;
            endcase
        end
    end

    // queue and octave count clamp
    vnf_front #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .octave_count (octave_reg),
        .item_valid   (item_valid),
        .item         (item),
        .item_ready   (item_ready)
    );

    // octave sequencer
    vnf_back #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_ready  (item_ready),
        .persistence (persistence_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    // output register frees up in the same cycle it is popped
    assign res_ready = !out_valid_reg || pop;

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_data_reg <= res_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && res_ready)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    assign empty       = !out_valid_reg;
    assign noise_value = out_data_reg;

endmodule

// ===== hdl/vnf_front.sv =====
// ============================================================================
// vnf_front - input side of the fractal value noise block
// accepts points, clamps the octave count and queues them for the back end
// ============================================================================
module vnf_front #(
    parameter int MAX_OCTAVES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [31:0]      x_coord,
    input  logic [31:0]      y_coord,
    input  logic [4:0]       octave_count,
    output logic             item_valid,
    output vnf_pkg::item_t   item,
    input  logic             item_ready
);

    vnf_pkg::item_t queue_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [4:0]     oct_clamped;
    logic           do_push;
    logic           do_pop;

    // zero means one octave, anything above the limit is cut to it
    always_comb
    begin
        oct_clamped = octave_count;
        if (octave_count == 5'd0)
            oct_clamped = 5'd1;
        else if ({1'b0, octave_count} > 6'(MAX_OCTAVES))
            oct_clamped = 5'(MAX_OCTAVES);
    end

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign item_valid = (count_reg != 2'd0);
    assign do_pop     = item_valid && item_ready;
    assign item       = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_reg[wr_ptr_reg] <= '{x: x_coord, y: y_coord, octaves: oct_clamped};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== hdl/vnf_hash.sv =====
// ============================================================================
// vnf_hash - pipelined lattice hash
// four stages, one multiply each, takes one lattice point per cycle
// ============================================================================
module vnf_hash (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [3:0]         in_tag,
    input  logic [31:0]        in_x,
    input  logic [31:0]        in_y,
    output logic               out_valid,
    output logic [3:0]         out_tag,
    output logic signed [31:0] out_value
);

    logic [3:0]  valid_reg;
    logic [3:0]  tag0_reg, tag1_reg, tag2_reg, tag3_reg;
    logic [31:0] n1_reg, n2_reg, n3_reg;
    logic [31:0] sq_reg, t_reg;
    logic [31:0] value_reg;
    logic [31:0] n_mix;
    logic [31:0] n_sum;
    logic [31:0] h_full;

    assign n_sum  = in_x + in_y * 32'd57;
    assign n_mix  = (n_sum << 13) ^ n_sum;
    assign h_full = n3_reg * t_reg + 32'd1376312589;

    always_ff @(posedge clk)
    begin
        n1_reg    <= n_mix;
        tag0_reg  <= in_tag;
        sq_reg    <= n1_reg * n1_reg;
        n2_reg    <= n1_reg;
        tag1_reg  <= tag0_reg;
        t_reg     <= sq_reg * 32'd15731 + 32'd789221;
        n3_reg    <= n2_reg;
        tag2_reg  <= tag1_reg;
        value_reg <= 32'h4000_0000 - {1'b0, h_full[30:0]};
        tag3_reg  <= tag2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 4'd0;
        else
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    assign out_valid = valid_reg[3];
    assign out_tag   = tag3_reg;
    assign out_value = $signed(value_reg);

endmodule

// ===== hdl/vnf_back.sv =====
// ============================================================================
// vnf_back - octave sequencer of the fractal value noise block
// splits, hashes a 4x4 lattice patch, smooths, blends and sums per octave
// ============================================================================
module vnf_back #(
    parameter int COS_TABLE_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  vnf_pkg::item_t item,
    output logic           item_ready,
    input  logic [15:0]    persistence,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [31:0]    res_data
);

    localparam int TAB_N = 1 << COS_TABLE_BITS;
    localparam int DW    = 38;
    localparam int PW    = DW + 18;

    typedef enum logic [3:0]
    {
        S_IDLE, S_SPLIT, S_HASH, S_MUL_I1, S_ADD_I1, S_MUL_I2, S_ADD_I2,
        S_MUL_R, S_ADD_R, S_MUL_AMP, S_ACC, S_DONE
    } state_t;

    typedef struct packed
    {
        logic [31:0] lat;
        logic [15:0] frac;
    } split_t;

    logic [16:0] wtab [TAB_N];

    generate
        for (genvar k = 0; k < TAB_N; k++)
        begin : g_wtab
            localparam logic [16:0] WK = vnf_pkg::cos_weight(k, COS_TABLE_BITS);
            assign wtab[k] = WK;
        end
    endgenerate

    state_t                state_reg;
    logic [31:0]           x_reg, y_reg;
    logic [4:0]            cnt_reg;
    logic [4:0]            oct_reg;
    logic [31:0]           bx_reg, by_reg;
    logic [16:0]           wx_reg, wy_reg;
    logic [16:0]           amp_reg;
    logic signed [35:0]    acc_reg [4];
    logic signed [DW-1:0]  i1_reg, i2_reg, r_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [63:0]    sum_reg;
    logic [4:0]            issue_reg;
    logic [4:0]            recv_reg;

    split_t                sx, sy;
    logic signed [DW-1:0]  mul_a;
    logic [16:0]           mul_w;
    logic signed [PW-1:0]  rnd_full;
    logic signed [DW-1:0]  rnd;
    logic signed [35:0]    contrib [4];
    logic [32:0]           amp_prod;
    logic signed [63:0]    sum_rnd;
    logic signed [63:0]    sum_q;

    logic                  h_in_valid;
    logic [3:0]            h_in_tag;
    logic                  hv_valid;
    logic [3:0]            hv_tag;
    logic signed [31:0]    hv_value;

    function automatic split_t do_split(input logic [31:0] raw, input logic [4:0] sh);
        logic [31:0] mag;
        logic [63:0] wide;
        split_t      r;
        mag    = raw[31] ? (~raw + 32'd1) : raw;
        wide   = {32'd0, mag} << sh;
        r.frac = wide[15:0];
        r.lat  = raw[31] ? (32'd0 - wide[47:16]) : wide[47:16];
        return r;
    endfunction

    assign sx = do_split(x_reg, oct_reg);
    assign sy = do_split(y_reg, oct_reg);

    assign h_in_valid = (state_reg == S_HASH) && !issue_reg[4];
    assign h_in_tag   = issue_reg[3:0];

    vnf_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h_in_valid),
        .in_tag    (h_in_tag),
        .in_x      (bx_reg + {30'd0, h_in_tag[1:0]}),
        .in_y      (by_reg + {30'd0, h_in_tag[3:2]}),
        .out_valid (hv_valid),
        .out_tag   (hv_tag),
        .out_value (hv_value)
    );

    // each patch point feeds the 3x3 kernels of the corners around it
    always_comb
    begin
        int dx;
        int dy;
        for (int c = 0; c < 4; c++)
        begin
            dx = int'(hv_tag[1:0]) - (c & 1);
            dy = int'(hv_tag[3:2]) - (c >> 1);
            if (dx >= 0 && dx <= 2 && dy >= 0 && dy <= 2)
                contrib[c] = 36'(hv_value) <<< (((dx == 1) ? 1 : 0) + ((dy == 1) ? 1 : 0));
            else
                contrib[c] = '0;
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_w = '0;
        case (state_reg)
            S_MUL_I1:
            begin
                mul_a = DW'(acc_reg[1]) - DW'(acc_reg[0]);
                mul_w = wx_reg;
            end
            S_MUL_I2:
            begin
                mul_a = DW'(acc_reg[3]) - DW'(acc_reg[2]);
                mul_w = wx_reg;
            end
            S_MUL_R:
            begin
                mul_a = i2_reg - i1_reg;
                mul_w = wy_reg;
            end
            S_MUL_AMP:
            begin
                mul_a = r_reg;
                mul_w = amp_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_w = '0;
            end
        endcase
    end

    assign rnd_full = (prod_reg + PW'(32768)) >>> 16;
    assign rnd      = rnd_full[DW-1:0];
    assign amp_prod = amp_reg * persistence + 33'd32768;

    // final rounding to q7.24 with saturation
    assign sum_rnd = sum_reg + 64'sd33554432;
    assign sum_q   = sum_rnd >>> 26;
    always_comb
    begin
        if (sum_q > 64'sd2147483647)
            res_data = 32'h7FFF_FFFF;
        else if (sum_q < -64'sd2147483648)
            res_data = 32'h8000_0000;
        else
            res_data = sum_q[31:0];
    end

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            issue_reg <= '0;
            recv_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        x_reg     <= item.x;
                        y_reg     <= item.y;
                        cnt_reg   <= item.octaves;
                        oct_reg   <= '0;
                        sum_reg   <= '0;
                        amp_reg   <= 17'd65536;
                        state_reg <= S_SPLIT;
                    end
                end
                S_SPLIT:
                begin
                    bx_reg    <= sx.lat - 32'd1;
                    by_reg    <= sy.lat - 32'd1;
                    wx_reg    <= wtab[sx.frac[15 -: COS_TABLE_BITS]];
                    wy_reg    <= wtab[sy.frac[15 -: COS_TABLE_BITS]];
                    for (int c = 0; c < 4; c++)
                        acc_reg[c] <= '0;
                    issue_reg <= '0;
                    recv_reg  <= '0;
                    state_reg <= S_HASH;
                end
                S_HASH:
                begin
                    if (h_in_valid)
                        issue_reg <= issue_reg + 5'd1;
                    if (hv_valid)
                    begin
                        for (int c = 0; c < 4; c++)
                            acc_reg[c] <= acc_reg[c] + contrib[c];
                        recv_reg <= recv_reg + 5'd1;
                        if (recv_reg == 5'd15)
                            state_reg <= S_MUL_I1;
                    end
                end
                S_MUL_I1, S_MUL_I2, S_MUL_R, S_MUL_AMP:
                begin
                    prod_reg  <= mul_a * $signed({1'b0, mul_w});
                    state_reg <= state_t'(state_reg + 4'd1);
                end
                S_ADD_I1:
                begin
                    i1_reg    <= DW'(acc_reg[0]) + rnd;
                    state_reg <= S_MUL_I2;
                end
                S_ADD_I2:
                begin
                    i2_reg    <= DW'(acc_reg[2]) + rnd;
                    state_reg <= S_MUL_R;
                end
                S_ADD_R:
                begin
                    r_reg     <= i1_reg + rnd;
                    state_reg <= S_MUL_AMP;
                end
                S_ACC:
                begin
                    sum_reg <= sum_reg + 64'(prod_reg);
                    amp_reg <= amp_prod[32:16];
                    if (({1'b0, oct_reg} + 6'd1) < {1'b0, cnt_reg})
                    begin
                        oct_reg   <= oct_reg + 5'd1;
                        state_reg <= S_SPLIT;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_hash_in_hash_state: assert property (@(posedge clk) disable iff (!rst_n)
        hv_valid |-> state_reg == S_HASH)
        else $error("hash result outside hash phase");
    a_recv_le_issue: assert property (@(posedge clk) disable iff (!rst_n)
        recv_reg <= issue_reg)
        else $error("more hash results than issued points");
    a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> amp_reg <= 17'd65536)
        else $error("amplitude above one");
    a_oct_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> oct_reg < cnt_reg)
        else $error("octave index beyond count");
    a_mul_to_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_R) |=> state_reg == S_ADD_R)
        else $error("blend multiply not followed by its add");
`endif

endmodule

// ===== dv/value_noise_2d_fractal_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// value_noise_2d_fractal_tb - self-checking bench for the fractal noise block
// points go in through a queue-style driver, noise sums come back through a
// monitor that compares each against an in-bench fixed point predictor
// ============================================================================
module value_noise_2d_fractal_tb;

    localparam int MAX_OCT   = 16;
    localparam int TBL_BITS  = 8;
    localparam int N_RANDOM  = 1200;
    localparam int WATCHDOG  = 20000;
    localparam int DRAIN_CYC = 600;

    typedef struct packed
    {
        logic [31:0] x;
        logic [31:0] y;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
    logic        empty;
    logic        pop;
    logic [31:0] noise_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    value_noise_2d_fractal u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .empty       (empty),
        .pop         (pop),
        .noise_value (noise_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // predictor copy of the registers
    logic [15:0] pred_persist;
    logic [4:0]  pred_octaves;
    logic [16:0] weight_lut [0:(1 << TBL_BITS) - 1];

    point_t      pending_points[$];
    logic [31:0] expected_noise[$];
    int          mismatches;
    int          idle_cycles;
    int          accepted_points;
    int          accepted_sums;
    bit          hold_sender;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // sin^2 weight, taylor series in q2.30, rebuilt here independently
    function automatic logic [16:0] sin2_weight(input int k);
        longint acc;
        longint ang;
        longint trm;
        longint unsigned sq;
        ang = (64'sd1686629713 * longint'(k)) >>> TBL_BITS;
        acc = ang;
        trm = ang;
        for (int n = 1; n <= 7; n++)
        begin
            trm = (((trm * ang) >>> 30) * ang) >>> 30;
            trm = trm / longint'((2 * n) * (2 * n + 1));
            acc = ((n % 2) == 1) ? acc - trm : acc + trm;
        end
        if (acc < 0)
            acc = 0;
        if (acc > (64'sd1 <<< 30))
            acc = 64'sd1 <<< 30;
        sq = (longint'(acc) * longint'(acc) + (64'd1 << 43)) >> 44;
        if (sq > 64'd65536)
            sq = 64'd65536;
        return sq[16:0];
    endfunction

    // shift right with rounding half up, floor semantics
    function automatic longint round_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint corner_value(input logic [31:0] lx, input logic [31:0] ly);
        logic [31:0] m;
        logic [31:0] h;
        m = lx + ly * 32'd57;
        m = (m << 13) ^ m;
        h = m * (m * m * 32'd15731 + 32'd789221) + 32'd1376312589;
        return (64'sd1 <<< 30) - longint'({33'd0, h[30:0]});
    endfunction

    function automatic longint kernel_sum(input logic [31:0] lx, input logic [31:0] ly);
        longint d;
        longint e;
        d = corner_value(lx - 1, ly - 1) + corner_value(lx + 1, ly - 1)
          + corner_value(lx - 1, ly + 1) + corner_value(lx + 1, ly + 1);
        e = corner_value(lx - 1, ly) + corner_value(lx + 1, ly)
          + corner_value(lx, ly - 1) + corner_value(lx, ly + 1);
        return d + 2 * e + 4 * corner_value(lx, ly);
    endfunction

    function automatic longint mix(input longint a, input longint b, input logic [16:0] w);
        return a + round_shift((b - a) * longint'({47'd0, w}), 16);
    endfunction

    // lattice integer truncated toward zero, fraction from the magnitude
    function automatic void split_coord(input logic [31:0] raw, input int sh,
                                        output logic [31:0] lat, output logic [15:0] frac);
        logic [63:0] mag;
        mag = raw[31] ? {32'd0, -raw} : {32'd0, raw};
        mag = mag << sh;
        frac = mag[15:0];
        lat = mag[47:16];
        if (raw[31])
            lat = -lat;
    endfunction

    function automatic logic [31:0] fractal_noise(input point_t p);
        int          cnt;
        longint unsigned amp;
        longint      total;
        longint      res;
        logic [31:0] ix, iy;
        logic [15:0] fx, fy;
        logic [16:0] wx, wy;
        longint      top, bot;
        cnt = pred_octaves;
        if (cnt < 1)
            cnt = 1;
        if (cnt > MAX_OCT)
            cnt = MAX_OCT;
        amp = 65536;
        total = 0;
        for (int o = 0; o < cnt; o++)
        begin
            split_coord(p.x, o, ix, fx);
            split_coord(p.y, o, iy, fy);
            wx = weight_lut[fx >> (16 - TBL_BITS)];
            wy = weight_lut[fy >> (16 - TBL_BITS)];
            top = mix(kernel_sum(ix, iy), kernel_sum(ix + 1, iy), wx);
            bot = mix(kernel_sum(ix, iy + 1), kernel_sum(ix + 1, iy + 1), wx);
            total += mix(top, bot, wy) * longint'(amp);
            amp = (amp * longint'(pred_persist) + 32768) >> 16;
        end
        res = round_shift(total, 26);
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res[31:0];
    endfunction

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // driver: one point per accepted item, random gap before each
    // ------------------------------------------------------------------------
    int send_gap;

    initial
    begin
        push     = 1'b0;
        x_coord  = '0;
        y_coord  = '0;
        send_gap = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                expected_noise.push_back(fractal_noise('{x_coord, y_coord}));
                accepted_points++;
                send_gap = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0)
                    send_gap = 0;
            end
            if (!(push && full))
            begin
                if (send_gap > 0 || hold_sender || pending_points.size() == 0)
                begin
                    push <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
                else
                begin
                    point_t nxt;
                    nxt = pending_points.pop_front();
                    push    <= 1'b1;
                    x_coord <= nxt.x;
                    y_coord <= nxt.y;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: pop with random stalls, check against the oldest expectation
    // ------------------------------------------------------------------------
    int pop_gap;

    initial
    begin
        pop     = 1'b0;
        pop_gap = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                accepted_sums++;
                if (expected_noise.size() == 0)
                begin
                    $error("noise_value: no item expected, actual %h", noise_value);
                    mismatches++;
                end
                else
                begin
                    logic [31:0] want;
                    want = expected_noise.pop_front();
                    if (noise_value !== want)
                    begin
                        $error("noise_value: expected %h actual %h", want, noise_value);
                        mismatches++;
                    end
                end
                pop_gap = $urandom_range(0, 6);
                if ($urandom_range(0, 3) == 0)
                    pop_gap = 0;
            end
            if (pop_gap > 0)
            begin
                pop <= 1'b0;
                pop_gap--;
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (pending_points.size() != 0 || expected_noise.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic write_reg(input vnf_pkg::cfg_reg_t idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == vnf_pkg::REG_PERSISTENCE)
            pred_persist = val;
        else
            pred_octaves = val[4:0];
        @(posedge clk);
    endtask

    // wait until every queued point has gone out and every sum has come back
    task automatic drain_all();
        while (pending_points.size() != 0 || push || expected_noise.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return {{16{1'b0}}, 16'($urandom())} - 32'h8000;
            2: return {$urandom_range(0, 1) ? 32'hFFFF0000 : 32'h00000000} ^ $urandom_range(0, 65535);
            3: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 65535)
                                           : 32'h80000000 + $urandom_range(0, 65535);
            default: return {16'($urandom_range(0, 255)), 16'($urandom())}
                            ^ ($urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h00000000);
        endcase
    endfunction

    task automatic queue_random(input int n);
        for (int k = 0; k < n; k++)
            pending_points.push_back('{rand_coord(), rand_coord()});
    endtask

    logic [31:0] edge_vals [8] = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                                   32'h00010000, 32'hFFFF0000, 32'h00008000, 32'hFFFF8001};

    initial
    begin
        cfg_valid       = 1'b0;
        cfg_index       = vnf_pkg::REG_PERSISTENCE;
        cfg_data        = '0;
        pred_persist    = vnf_pkg::PERSISTENCE_RESET;
        pred_octaves    = vnf_pkg::OCTAVE_RESET;
        mismatches      = 0;
        idle_cycles     = 0;
        accepted_points = 0;
        accepted_sums   = 0;
        hold_sender     = 1'b0;
        for (int k = 0; k < (1 << TBL_BITS); k++)
            weight_lut[k] = sin2_weight(k);
        @(posedge rst_n);
        @(posedge clk);

        // directed: reset settings, extremes of both coordinates
        for (int k = 0; k < 8; k++)
            pending_points.push_back('{edge_vals[k], edge_vals[(k * 3 + 1) % 8]});
        pending_points.push_back('{32'h55555555, 32'hAAAAAAAA});
        pending_points.push_back('{32'hAAAAAAAA, 32'h55555555});
        drain_all();

        // octave count zero is treated as one, above the maximum is clamped
        write_reg(vnf_pkg::REG_OCTAVE_COUNT, 16'd0);
        write_reg(vnf_pkg::REG_PERSISTENCE, 16'hFFFF);
        pending_points.push_back('{32'h7FFFFFFF, 32'h80000000});
        pending_points.push_back('{32'h00012345, 32'hFFFE1234});
        drain_all();
        write_reg(vnf_pkg::REG_OCTAVE_COUNT, 16'd31);
        pending_points.push_back('{32'h80000000, 32'h7FFFFFFF});
        pending_points.push_back('{32'hFFFFFFFF, 32'h00000001});
        pending_points.push_back('{32'h12345678, 32'h9ABCDEF0});
        drain_all();
        // saturation is most likely with many full-amplitude octaves
        write_reg(vnf_pkg::REG_OCTAVE_COUNT, 16'd16);
        for (int k = 0; k < 6; k++)
            pending_points.push_back('{rand_coord(), rand_coord()});
        drain_all();

        // random phases across register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(vnf_pkg::REG_PERSISTENCE, 16'd0);
                    write_reg(vnf_pkg::REG_OCTAVE_COUNT, 16'd1);
                end
                1:
                begin
                    write_reg(vnf_pkg::REG_PERSISTENCE, 16'd32768);
                    write_reg(vnf_pkg::REG_OCTAVE_COUNT, 16'd4);
                end
                7:
                begin
                    write_reg(vnf_pkg::REG_PERSISTENCE, 16'hFFFF);
                    write_reg(vnf_pkg::REG_OCTAVE_COUNT, 16'd16);
                end
                default:
                begin
                    write_reg(vnf_pkg::REG_PERSISTENCE, 16'($urandom()));
                    write_reg(vnf_pkg::REG_OCTAVE_COUNT, 16'($urandom_range(0, 31)));
                end
            endcase
            queue_random(N_RANDOM / 8);
            if (ph == 3)
            begin
                // pause the sender until every expected sum has returned
                while (pending_points.size() > N_RANDOM / 16)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (push || expected_noise.size() != 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain_all();
        end

        $display("covered %0d points and %0d sums over persistence 0..65535 and octaves 0..31",
                 accepted_points, accepted_sums);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/vnf_pkg.sv
hdl/vnf_front.sv
hdl/vnf_hash.sv
hdl/vnf_back.sv
hdl/value_noise_2d_fractal.sv
dv/value_noise_2d_fractal_tb.sv
